// ----- sv/sci_pkg.sv -----
// ----------------------------------------------------------------------------
// sci_pkg
// Shared constants and the table generator for the sine/cosine interpolator.
// ----------------------------------------------------------------------------
package sci_pkg;

   localparam int ANGLE_BITS     = 24;
   localparam int DEG_FULL       = 360;
   localparam int DEG_QUARTER    = 90;
   localparam int TABLE_ENTRIES  = 361;
   localparam int DEG_BITS       = 9;
   localparam int BANK_ADDR_BITS = 8;
   localparam int EVEN_DEPTH     = (TABLE_ENTRIES + 1) / 2;
   localparam int ODD_DEPTH      = (TABLE_ENTRIES - 1) / 2;
   localparam int Q30_FB         = 30;

   localparam logic [63:0] PI_Q32 = 64'd13493037705;

   // sine of a whole degree 0..90 in q30, taylor series through x^23
   function automatic logic signed [63:0] quarter_sin_q30(input int d);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      x = (64'(d) * PI_Q32 + 64'd360) / 64'd720;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = signed'(x);
      for (int k = 1; k <= 11; k++) begin
         term = (term * x2 + (64'd1 << 29)) >> 30;
         case (k)
            1:       term = (term + 64'd3) / 64'd6;
            2:       term = (term + 64'd10) / 64'd20;
            3:       term = (term + 64'd21) / 64'd42;
            4:       term = (term + 64'd36) / 64'd72;
            5:       term = (term + 64'd55) / 64'd110;
            6:       term = (term + 64'd78) / 64'd156;
            7:       term = (term + 64'd105) / 64'd210;
            8:       term = (term + 64'd136) / 64'd272;
            9:       term = (term + 64'd171) / 64'd342;
            10:      term = (term + 64'd210) / 64'd420;
            default: term = (term + 64'd253) / 64'd506;
         endcase
         if (k % 2 == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      return sum;
   endfunction

   // table entry for a whole degree 0..450, rounded to out_fb fraction bits
   function automatic logic signed [31:0] sin_entry(input int deg, input int out_fb);
      int dd;
      int qd;
      int e;
      int sh;
      logic signed [63:0] v;
      logic signed [63:0] mag;
      logic signed [63:0] r;
      dd = deg;
      if (dd >= DEG_FULL) begin
         dd = dd - DEG_FULL;
      end
      if (dd >= 3 * DEG_QUARTER) begin
         qd = 3;
         e = dd - 3 * DEG_QUARTER;
      end else if (dd >= 2 * DEG_QUARTER) begin
         qd = 2;
         e = dd - 2 * DEG_QUARTER;
      end else if (dd >= DEG_QUARTER) begin
         qd = 1;
         e = dd - DEG_QUARTER;
      end else begin
         qd = 0;
         e = dd;
      end
      if (qd == 1 || qd == 3) begin
         v = quarter_sin_q30(DEG_QUARTER - e);
      end else begin
         v = quarter_sin_q30(e);
      end
      if (qd >= 2) begin
         v = -v;
      end
      sh = Q30_FB - out_fb;
      mag = (v < 0) ? -v : v;
      r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      return 32'((v < 0) ? -r : r);
   endfunction

endpackage

// ----- sv/sine_cosine_table_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// sine_cosine_table_interpolator_unit
// Sine and cosine of an angle in degrees by one-degree table lookup with
// linear interpolation.
// ----------------------------------------------------------------------------
// Takes one angle per clock and returns its sine and cosine. busy is always
// low and results cannot be held off, so every transfer on req_ gives
// exactly one rsp_strobe pulse, in order. The pipeline has four stages of
// modulo-360 reduction (reciprocal multiply, remainder, correction), one
// registered table read, and two stages of interpolation with its multiply.
// Outputs are signed with OUT_BITS-2 fraction bits; a multiple of 360
// degrees gives the table entry for zero exactly.
module sine_cosine_table_interpolator_unit #(
   parameter int FRAC_BITS = 8,
   parameter int OUT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [sci_pkg::ANGLE_BITS-1:0] req_angle,
   output logic                                 rsp_strobe,
   output logic signed [OUT_BITS-1:0]           rsp_sine,
   output logic signed [OUT_BITS-1:0]           rsp_cosine
);

   localparam int LATENCY = 7;
   localparam int AB      = sci_pkg::BANK_ADDR_BITS;
   localparam int NB      = sci_pkg::DEG_BITS;

   logic                 red_valid;
   logic [NB-1:0]        red_whole;
   logic [FRAC_BITS-1:0] red_frac;
   logic [NB-1:0]        next_whole;
   logic [AB-1:0]        even_addr;
   logic [AB-1:0]        odd_addr;

   logic signed [OUT_BITS-1:0] sin_even;
   logic signed [OUT_BITS-1:0] sin_odd;
   logic signed [OUT_BITS-1:0] cos_even;
   logic signed [OUT_BITS-1:0] cos_odd;

   logic [2:0]           valid_ff;
   logic [2:0]           valid_in;
   logic                 odd_ff;
   logic [FRAC_BITS-1:0] frac_ff;

   assign busy = 1'b0;

   sci_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .angle     (req_angle),
      .out_valid (red_valid),
      .deg_whole (red_whole),
      .deg_frac  (red_frac)
   );

   // entries n and n+1 always fall in different banks
   assign next_whole = red_whole + NB'(1);
   assign even_addr  = next_whole[NB-1:1];
   assign odd_addr   = red_whole[NB-1:1];

   sci_rom #(
      .OUT_BITS (OUT_BITS),
      .PHASE    (0)
   ) u_sin_rom (
      .clock     (clock),
      .even_addr (even_addr),
      .odd_addr  (odd_addr),
      .even_data (sin_even),
      .odd_data  (sin_odd)
   );

   sci_rom #(
      .OUT_BITS (OUT_BITS),
      .PHASE    (sci_pkg::DEG_QUARTER)
   ) u_cos_rom (
      .clock     (clock),
      .even_addr (even_addr),
      .odd_addr  (odd_addr),
      .even_data (cos_even),
      .odd_data  (cos_odd)
   );

   // control that travels beside the table read
   always_ff @(posedge clock) begin
      odd_ff  <= red_whole[0];
      frac_ff <= red_frac;
   end

   assign valid_in = {valid_ff[1:0], red_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   sci_interp #(
      .FRAC_BITS (FRAC_BITS),
      .OUT_BITS  (OUT_BITS)
   ) u_sin_interp (
      .clock     (clock),
      .odd_sel   (odd_ff),
      .frac      (frac_ff),
      .even_data (sin_even),
      .odd_data  (sin_odd),
      .result    (rsp_sine)
   );

   sci_interp #(
      .FRAC_BITS (FRAC_BITS),
      .OUT_BITS  (OUT_BITS)
   ) u_cos_interp (
      .clock     (clock),
      .odd_sel   (odd_ff),
      .frac      (frac_ff),
      .even_data (cos_even),
      .odd_data  (cos_odd),
      .result    (rsp_cosine)
   );

   assign rsp_strobe = valid_ff[2];

   // every result comes from a matching earlier transfer on start
   a_strobe_follows_start : assert property (
      @(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY)
   ) else $error("result strobe without a matching request");

   // interpolated values never leave the span of the table
   a_result_in_range : assert property (
      @(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_sine <= $signed(OUT_BITS'(1) <<< (OUT_BITS - 2))) &&
         (rsp_sine >= -$signed(OUT_BITS'(1) <<< (OUT_BITS - 2))) &&
         (rsp_cosine <= $signed(OUT_BITS'(1) <<< (OUT_BITS - 2))) &&
         (rsp_cosine >= -$signed(OUT_BITS'(1) <<< (OUT_BITS - 2)))
   ) else $error("interpolated result out of range");

   // zero degrees gives sine zero and cosine one
   a_zero_angle : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_angle, LATENCY) == '0)) |->
         (rsp_sine == '0) &&
         (rsp_cosine == $signed(OUT_BITS'(1) <<< (OUT_BITS - 2)))
   ) else $error("wrong result for zero angle");

endmodule

// ----- sv/sci_reduce.sv -----
// ----------------------------------------------------------------------------
// sci_reduce
// Four-stage modulo-360 angle reduction: bias, reciprocal quotient,
// remainder, final correction and degree/fraction split.
// ----------------------------------------------------------------------------
module sci_reduce #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [sci_pkg::ANGLE_BITS-1:0] angle,
   output logic                                 out_valid,
   output logic [sci_pkg::DEG_BITS-1:0]         deg_whole,
   output logic [FRAC_BITS-1:0]                 deg_frac
);

   localparam int AW     = sci_pkg::ANGLE_BITS;
   localparam int FULL   = sci_pkg::DEG_FULL << FRAC_BITS;
   localparam int XW     = $clog2((1 << AW) + FULL);
   localparam int OFFSET = (FULL - ((1 << (AW - 1)) % FULL)) % FULL;
   localparam int SH     = FRAC_BITS + 3;
   localparam int DIVISOR = sci_pkg::DEG_FULL >> 3;
   localparam int YW     = XW - SH;
   localparam int RS     = YW + 6;
   localparam int MW     = RS - 5;
   localparam int PW     = YW + MW;
   localparam int QW     = PW - RS;
   localparam int RECIP  = (1 << RS) / DIVISOR;
   localparam int RW     = $clog2(2 * FULL);

   logic [3:0]          valid_ff;
   logic [3:0]          valid_in;
   logic [XW-1:0]       biased_ff;
   logic [XW-1:0]       biased_in;
   logic [XW-1:0]       biased2_ff;
   logic [QW-1:0]       quot_ff;
   logic [QW-1:0]       quot_in;
   logic [RW-1:0]       rem_ff;
   logic [RW-1:0]       rem_in;
   logic [sci_pkg::DEG_BITS-1:0] whole_ff;
   logic [sci_pkg::DEG_BITS-1:0] whole_in;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [FRAC_BITS-1:0] frac_in;

   logic [YW-1:0] scaled;
   logic [PW-1:0] prod;
   logic [XW-1:0] quot_full;
   logic [XW-1:0] rem_wide;
   logic [RW-1:0] rem_fix;

   assign valid_in = {valid_ff[2:0], in_valid};

   // flipping the sign bit adds 2^23; the offset restores congruence mod 360
   assign biased_in = XW'({~angle[AW-1], angle[AW-2:0]}) + XW'(OFFSET);

   // 360 << f = 45 << (f + 3): shift out the power of two, divide by 45
   assign scaled  = biased_ff[XW-1:SH];
   assign prod    = PW'(scaled) * PW'(RECIP);
   assign quot_in = prod[PW-1:RS];

   // estimate is exact or one low, so the remainder stays below twice full
   assign quot_full = XW'(quot_ff) * XW'(FULL);
   assign rem_wide  = biased2_ff - quot_full;
   assign rem_in    = rem_wide[RW-1:0];

   assign rem_fix  = (rem_ff >= RW'(FULL)) ? rem_ff - RW'(FULL) : rem_ff;
   assign whole_in = rem_fix[FRAC_BITS +: sci_pkg::DEG_BITS];
   assign frac_in  = rem_fix[FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      biased_ff  <= biased_in;
      biased2_ff <= biased_ff;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      whole_ff   <= whole_in;
      frac_ff    <= frac_in;
   end

   assign out_valid = valid_ff[3];
   assign deg_whole = whole_ff;
   assign deg_frac  = frac_ff;

endmodule

// ----- sv/sci_rom.sv -----
// ----------------------------------------------------------------------------
// sci_rom
// One-degree sine table split into even and odd banks so that neighboring
// entries are read in the same cycle. Registered read.
// ----------------------------------------------------------------------------
module sci_rom #(
   parameter int OUT_BITS = 16,
   parameter int PHASE    = 0
) (
   input  logic                                clock,
   input  logic [sci_pkg::BANK_ADDR_BITS-1:0]  even_addr,
   input  logic [sci_pkg::BANK_ADDR_BITS-1:0]  odd_addr,
   output logic signed [OUT_BITS-1:0]          even_data,
   output logic signed [OUT_BITS-1:0]          odd_data
);

   logic [OUT_BITS-1:0] even_tbl [sci_pkg::EVEN_DEPTH];
   logic [OUT_BITS-1:0] odd_tbl  [sci_pkg::ODD_DEPTH];
   logic [OUT_BITS-1:0] even_data_ff;
   logic [OUT_BITS-1:0] odd_data_ff;

   for (genvar i = 0; i < sci_pkg::EVEN_DEPTH; i++) begin : g_even
      localparam logic signed [31:0] ENTRY = sci_pkg::sin_entry(2 * i + PHASE, OUT_BITS - 2);
      assign even_tbl[i] = ENTRY[OUT_BITS-1:0];
   end

   for (genvar i = 0; i < sci_pkg::ODD_DEPTH; i++) begin : g_odd
      localparam logic signed [31:0] ENTRY =
         sci_pkg::sin_entry(2 * i + 1 + PHASE, OUT_BITS - 2);
      assign odd_tbl[i] = ENTRY[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      even_data_ff <= even_tbl[even_addr];
      odd_data_ff  <= odd_tbl[odd_addr];
   end

   assign even_data = signed'(even_data_ff);
   assign odd_data  = signed'(odd_data_ff);

endmodule

// ----- sv/sci_interp.sv -----
// ----------------------------------------------------------------------------
// sci_interp
// Two-stage linear interpolation between neighboring table entries with
// round half up.
// ----------------------------------------------------------------------------
module sci_interp #(
   parameter int FRAC_BITS = 8,
   parameter int OUT_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       odd_sel,
   input  logic [FRAC_BITS-1:0]       frac,
   input  logic signed [OUT_BITS-1:0] even_data,
   input  logic signed [OUT_BITS-1:0] odd_data,
   output logic signed [OUT_BITS-1:0] result
);

   localparam int DW = OUT_BITS + 1;
   localparam int VW = OUT_BITS + FRAC_BITS + 2;

   logic signed [OUT_BITS-1:0] base_ff;
   logic signed [OUT_BITS-1:0] base_in;
   logic signed [DW-1:0]       slope_ff;
   logic signed [DW-1:0]       slope_in;
   logic [FRAC_BITS-1:0]       frac_ff;
   logic [OUT_BITS-1:0]        result_ff;
   logic [OUT_BITS-1:0]        result_in;

   logic signed [OUT_BITS-1:0] next_entry;
   logic signed [VW-1:0]       sum;

   // an odd whole degree sits in the odd bank, its successor in the even one
   assign base_in    = odd_sel ? odd_data : even_data;
   assign next_entry = odd_sel ? even_data : odd_data;
   assign slope_in   = DW'(next_entry) - DW'(base_in);

   // product is formed at full sum width so a steep slope cannot wrap
   assign sum = (VW'(base_ff) <<< FRAC_BITS)
              + (VW'($signed({1'b0, frac_ff})) * VW'(slope_ff))
              + (VW'(1) <<< (FRAC_BITS - 1));

   // arithmetic shift right is floor, so the added half rounds ties upward
   assign result_in = sum[FRAC_BITS +: OUT_BITS];

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      slope_ff  <= slope_in;
      frac_ff   <= frac;
      result_ff <= result_in;
   end

   assign result = signed'(result_ff);

endmodule
